// ===== design/csv_record_field_parser_assert.svh =====
// assertion macros for the csv record field parser checker
`ifndef CSV_RECORD_FIELD_PARSER_ASSERT_SVH
`define CSV_RECORD_FIELD_PARSER_ASSERT_SVH

// same-cycle implication, sampled on the rising clock edge
`define CSVRFP_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define CSVRFP_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== design/csvrfp_pkg.sv =====
// package: constants, types and control structs of the csv record field parser
`timescale 1ns / 1ps

package csvrfp_pkg;

   localparam int MAX_FIELDS  = 64;
   localparam int BLANK_LIMIT = 32;

   localparam int BYTE_W = 8;
   localparam int FIDX_W = 6;
   localparam int ERR_W  = 2;
   localparam int FCNT_W = $clog2(MAX_FIELDS + 1);
   localparam int HCNT_W = $clog2(BLANK_LIMIT + 1);

   localparam logic [BYTE_W-1:0] CH_NUL   = 8'h00;
   localparam logic [BYTE_W-1:0] CH_QUOTE = 8'h22;
   localparam logic [BYTE_W-1:0] CH_COMMA = 8'h2C;
   localparam logic [BYTE_W-1:0] CH_LF    = 8'h0A;
   localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;
   localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;
   localparam logic [BYTE_W-1:0] CH_TAB   = 8'h09;

   localparam logic [ERR_W-1:0] ERR_NONE       = 2'd0;
   localparam logic [ERR_W-1:0] ERR_MANY_FIELD = 2'd1;
   localparam logic [ERR_W-1:0] ERR_BLANK_OVF  = 2'd2;

   typedef enum logic [2:0] {
      MODE_START,
      MODE_PLAIN,
      MODE_QUOTED,
      MODE_QCLOSE,
      MODE_DROP
   } field_mode_type;

   typedef enum logic [1:0] {
      CTL_RUN,
      CTL_FLUSH,
      CTL_CONTENT
   } ctl_state_type;

   typedef struct packed {
      logic take;
      logic flush_emit;
      logic content_emit;
   } ctl_cmd_type;

   typedef struct packed {
      logic slot_free;
      logic item_flushes;
      logic last_blank;
   } dp_status_type;

endpackage

// ===== design/csv_record_field_parser.sv =====
// top level: csv record and field parser, controller plus datapath
`timescale 1ns / 1ps

// Streams CSV text one byte per beat and returns field content bytes with
// field-end and record-end marks. Records end at CR, LF or CR LF while the
// quote parity is even; a leading quote opens a quoted field where a doubled
// quote gives one quote. Blank-only records are skipped, so leading spaces
// and tabs are held (up to BLANK_LIMIT) and replayed once the record proves
// visible. Throughput is one input byte per cycle, each giving at most one
// result beat straight into the single output register, and the next byte is
// taken while that result waits as long as the consumer takes it in the same
// cycle. A byte that ends a run of held blanks is taken first; the blanks are
// then replayed through the output register one per cycle while the consumer
// takes them, and its own result follows. Errors: code 1 when a record
// exceeds MAX_FIELDS fields, code 2 when held blanks overflow; either drops the
// rest of the record, whose terminator still gives a record_end beat.

module csv_record_field_parser (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [csvrfp_pkg::BYTE_W-1:0] req_byte_req,
   input  logic                          req_end_of_input,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [csvrfp_pkg::BYTE_W-1:0] rsp_data_byte,
   output logic                          rsp_has_byte,
   output logic                          rsp_field_end,
   output logic                          rsp_record_end,
   output logic [csvrfp_pkg::FIDX_W-1:0] rsp_field_index,
   output logic [csvrfp_pkg::ERR_W-1:0]  rsp_error_code,
   output logic                          rsp_last
);
   import csvrfp_pkg::*;

   // command and status between the sequencer and the datapath
   ctl_cmd_type   cmd;
   dp_status_type status;

   // sequencer: intake, blank replay, deferred content beat
   csvrfp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // parse state, blank hold and output register
   csvrfp_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .req_byte_req     (req_byte_req),
      .req_end_of_input (req_end_of_input),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_data_byte    (rsp_data_byte),
      .rsp_has_byte     (rsp_has_byte),
      .rsp_field_end    (rsp_field_end),
      .rsp_record_end   (rsp_record_end),
      .rsp_field_index  (rsp_field_index),
      .rsp_error_code   (rsp_error_code),
      .rsp_last         (rsp_last),
      .cmd              (cmd),
      .status           (status)
   );

endmodule

// ===== design/csvrfp_ctrl.sv =====
// controller: sequences byte intake, held blank replay and the deferred content beat
`timescale 1ns / 1ps

module csvrfp_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  csvrfp_pkg::dp_status_type status,
   output csvrfp_pkg::ctl_cmd_type   cmd
);
   import csvrfp_pkg::*;

   ctl_state_type state_ff;
   ctl_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= CTL_RUN;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         CTL_RUN: begin
            if (req_valid && status.slot_free && status.item_flushes) begin
               state_in = CTL_FLUSH;
            end
         end
         CTL_FLUSH: begin
            if (status.slot_free && status.last_blank) begin
               state_in = CTL_CONTENT;
            end
         end
         CTL_CONTENT: begin
            if (status.slot_free) begin
               state_in = CTL_RUN;
            end
         end
         default: begin
            state_in = CTL_RUN;
         end
      endcase
   end

   always_comb begin
      req_ready        = 1'b0;
      cmd.take         = 1'b0;
      cmd.flush_emit   = 1'b0;
      cmd.content_emit = 1'b0;
      case (state_ff)
         CTL_RUN: begin
            req_ready = status.slot_free;
            cmd.take  = req_valid && status.slot_free;
         end
         CTL_FLUSH: begin
            cmd.flush_emit = status.slot_free;
         end
         CTL_CONTENT: begin
            cmd.content_emit = status.slot_free;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

endmodule

// ===== design/csvrfp_datapath.sv =====
// datapath: record and field state, blank hold register and the result register
`timescale 1ns / 1ps

module csvrfp_datapath (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic [csvrfp_pkg::BYTE_W-1:0]          req_byte_req,
   input  logic                                   req_end_of_input,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic [csvrfp_pkg::BYTE_W-1:0]          rsp_data_byte,
   output logic                                   rsp_has_byte,
   output logic                                   rsp_field_end,
   output logic                                   rsp_record_end,
   output logic [csvrfp_pkg::FIDX_W-1:0]          rsp_field_index,
   output logic [csvrfp_pkg::ERR_W-1:0]           rsp_error_code,
   output logic                                   rsp_last,
   input  csvrfp_pkg::ctl_cmd_type                cmd,
   output csvrfp_pkg::dp_status_type              status
);
   import csvrfp_pkg::*;

   // record state
   logic                   parity_ff,   parity_in;
   logic                   swallow_ff,  swallow_in;
   logic                   visible_ff,  visible_in;
   field_mode_type         mode_ff,     mode_in;
   logic                   after_ff,    after_in;
   logic [FCNT_W-1:0]      fcnt_ff,     fcnt_in;
   logic [HCNT_W-1:0]      hcnt_ff,     hcnt_in;
   logic [BLANK_LIMIT-1:0] kinds_ff,    kinds_in;
   logic [BYTE_W-1:0]      pending_ff,  pending_in;

   // result register
   logic                   rvalid_ff,   rvalid_in;
   logic [BYTE_W-1:0]      rbyte_ff,    rbyte_in;
   logic                   rhas_ff,     rhas_in;
   logic                   rfe_ff,      rfe_in;
   logic                   rre_ff,      rre_in;
   logic [FIDX_W-1:0]      ridx_ff,     ridx_in;
   logic [ERR_W-1:0]       rerr_ff,     rerr_in;
   logic                   rlast_ff,    rlast_in;

   logic                   res_load;
   logic                   do_end;
   logic                   content_go;
   logic [BYTE_W-1:0]      cc;
   logic                   is_blank;
   logic                   is_term;
   logic                   swallowed;
   logic [FIDX_W-1:0]      cur_idx;

   assign is_blank  = (req_byte_req == CH_SPACE) || (req_byte_req == CH_TAB);
   assign is_term   = ((req_byte_req == CH_CR) || (req_byte_req == CH_LF)) && !parity_ff;
   assign swallowed = swallow_ff && (req_byte_req == CH_LF);
   assign cur_idx   = FIDX_W'(fcnt_ff);

   assign status.slot_free    = !rvalid_ff || rsp_ready;
   assign status.last_blank   = (hcnt_ff == HCNT_W'(1));
   assign status.item_flushes = !req_end_of_input && (req_byte_req != CH_NUL) && !swallowed
                                && !is_term && !visible_ff && !is_blank
                                && (hcnt_ff != '0);

   always_comb begin
      parity_in  = parity_ff;
      swallow_in = swallow_ff;
      visible_in = visible_ff;
      mode_in    = mode_ff;
      after_in   = after_ff;
      fcnt_in    = fcnt_ff;
      hcnt_in    = hcnt_ff;
      kinds_in   = kinds_ff;
      pending_in = pending_ff;
      res_load   = 1'b0;
      rbyte_in   = CH_NUL;
      rhas_in    = 1'b0;
      rfe_in     = 1'b0;
      rre_in     = 1'b0;
      ridx_in    = '0;
      rerr_in    = ERR_NONE;
      rlast_in   = 1'b1;
      do_end     = 1'b0;
      content_go = 1'b0;
      cc         = req_byte_req;

      if (cmd.take) begin
         if (req_end_of_input) begin
            swallow_in = 1'b0;
            do_end     = 1'b1;
         end else if (req_byte_req == CH_NUL) begin
            swallow_in = swallow_ff;
         end else if (swallowed) begin
            swallow_in = 1'b0;
         end else begin
            swallow_in = 1'b0;
            if (is_term) begin
               swallow_in = (req_byte_req == CH_CR);
               do_end     = 1'b1;
            end else begin
               parity_in = parity_ff ^ (req_byte_req == CH_QUOTE);
               if (!visible_ff && is_blank) begin
                  if (hcnt_ff >= HCNT_W'(BLANK_LIMIT)) begin
                     // blank hold overflow: drop the rest of the record
                     res_load   = 1'b1;
                     rerr_in    = ERR_BLANK_OVF;
                     hcnt_in    = '0;
                     kinds_in   = '0;
                     visible_in = 1'b1;
                     mode_in    = MODE_DROP;
                  end else begin
                     for (int i = 0; i < BLANK_LIMIT; i++) begin
                        kinds_in[i] = kinds_ff[i] ||
                                      ((req_byte_req == CH_TAB) && (hcnt_ff == HCNT_W'(i)));
                     end
                     hcnt_in = hcnt_ff + HCNT_W'(1);
                  end
               end else if (!visible_ff && (hcnt_ff != '0)) begin
                  // replay held blanks first, content beat follows
                  visible_in = 1'b1;
                  mode_in    = MODE_PLAIN;
                  pending_in = req_byte_req;
               end else begin
                  visible_in = 1'b1;
                  content_go = 1'b1;
               end
            end
         end
      end else if (cmd.flush_emit) begin
         res_load = 1'b1;
         rbyte_in = kinds_ff[0] ? CH_TAB : CH_SPACE;
         rhas_in  = 1'b1;
         rlast_in = 1'b0;
         kinds_in = kinds_ff >> 1;
         hcnt_in  = hcnt_ff - HCNT_W'(1);
      end else if (cmd.content_emit) begin
         cc         = pending_ff;
         content_go = 1'b1;
      end

      if (do_end) begin
         if (visible_ff) begin
            res_load = 1'b1;
            rre_in   = 1'b1;
            if (mode_ff == MODE_DROP) begin
               rfe_in = 1'b0;
            end else if ((mode_ff == MODE_START) && after_ff &&
                         (fcnt_ff >= FCNT_W'(MAX_FIELDS))) begin
               rfe_in = 1'b0;
            end else begin
               rfe_in  = 1'b1;
               ridx_in = cur_idx;
            end
         end
         parity_in  = 1'b0;
         visible_in = 1'b0;
         mode_in    = MODE_START;
         after_in   = 1'b0;
         fcnt_in    = '0;
         hcnt_in    = '0;
         kinds_in   = '0;
      end

      if (content_go) begin
         case (mode_ff)
            MODE_START: begin
               if (fcnt_ff >= FCNT_W'(MAX_FIELDS)) begin
                  res_load = 1'b1;
                  rerr_in  = ERR_MANY_FIELD;
                  mode_in  = MODE_DROP;
               end else if (cc == CH_QUOTE) begin
                  after_in = 1'b0;
                  mode_in  = MODE_QUOTED;
               end else if (cc == CH_COMMA) begin
                  res_load = 1'b1;
                  rfe_in   = 1'b1;
                  ridx_in  = cur_idx;
                  fcnt_in  = fcnt_ff + FCNT_W'(1);
                  after_in = 1'b1;
                  mode_in  = MODE_START;
               end else begin
                  after_in = 1'b0;
                  res_load = 1'b1;
                  rbyte_in = cc;
                  rhas_in  = 1'b1;
                  ridx_in  = cur_idx;
                  mode_in  = MODE_PLAIN;
               end
            end
            MODE_PLAIN: begin
               res_load = 1'b1;
               ridx_in  = cur_idx;
               if (cc == CH_COMMA) begin
                  rfe_in   = 1'b1;
                  fcnt_in  = fcnt_ff + FCNT_W'(1);
                  after_in = 1'b1;
                  mode_in  = MODE_START;
               end else begin
                  rbyte_in = cc;
                  rhas_in  = 1'b1;
               end
            end
            MODE_QUOTED: begin
               if (cc == CH_QUOTE) begin
                  mode_in = MODE_QCLOSE;
               end else begin
                  res_load = 1'b1;
                  rbyte_in = cc;
                  rhas_in  = 1'b1;
                  ridx_in  = cur_idx;
               end
            end
            MODE_QCLOSE: begin
               res_load = 1'b1;
               ridx_in  = cur_idx;
               if (cc == CH_QUOTE) begin
                  rbyte_in = CH_QUOTE;
                  rhas_in  = 1'b1;
                  mode_in  = MODE_QUOTED;
               end else if (cc == CH_COMMA) begin
                  rfe_in   = 1'b1;
                  fcnt_in  = fcnt_ff + FCNT_W'(1);
                  after_in = 1'b1;
                  mode_in  = MODE_START;
               end else begin
                  // junk after closing quote ends the field and the record content
                  rfe_in  = 1'b1;
                  fcnt_in = fcnt_ff + FCNT_W'(1);
                  mode_in = MODE_DROP;
               end
            end
            default: begin
               mode_in = MODE_DROP;
            end
         endcase
      end
   end

   always_comb begin
      rvalid_in = rvalid_ff;
      if (res_load) begin
         rvalid_in = 1'b1;
      end else if (rsp_ready) begin
         rvalid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         parity_ff  <= 1'b0;
         swallow_ff <= 1'b0;
         visible_ff <= 1'b0;
         mode_ff    <= MODE_START;
         after_ff   <= 1'b0;
         fcnt_ff    <= '0;
         hcnt_ff    <= '0;
         kinds_ff   <= '0;
         rvalid_ff  <= 1'b0;
      end else begin
         parity_ff  <= parity_in;
         swallow_ff <= swallow_in;
         visible_ff <= visible_in;
         mode_ff    <= mode_in;
         after_ff   <= after_in;
         fcnt_ff    <= fcnt_in;
         hcnt_ff    <= hcnt_in;
         kinds_ff   <= kinds_in;
         rvalid_ff  <= rvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      pending_ff <= pending_in;
      if (res_load) begin
         rbyte_ff <= rbyte_in;
         rhas_ff  <= rhas_in;
         rfe_ff   <= rfe_in;
         rre_ff   <= rre_in;
         ridx_ff  <= ridx_in;
         rerr_ff  <= rerr_in;
         rlast_ff <= rlast_in;
      end
   end

   assign rsp_valid       = rvalid_ff;
   assign rsp_data_byte   = rbyte_ff;
   assign rsp_has_byte    = rhas_ff;
   assign rsp_field_end   = rfe_ff;
   assign rsp_record_end  = rre_ff;
   assign rsp_field_index = ridx_ff;
   assign rsp_error_code  = rerr_ff;
   assign rsp_last        = rlast_ff;

endmodule

// ===== design/csvrfp_checker.sv =====
// port-level checker for the csv record field parser and its bind
`timescale 1ns / 1ps

`include "csv_record_field_parser_assert.svh"

module csvrfp_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_ready,
   input logic [csvrfp_pkg::BYTE_W-1:0] req_byte_req,
   input logic                          req_end_of_input,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [csvrfp_pkg::BYTE_W-1:0] rsp_data_byte,
   input logic                          rsp_has_byte,
   input logic                          rsp_field_end,
   input logic                          rsp_record_end,
   input logic [csvrfp_pkg::FIDX_W-1:0] rsp_field_index,
   input logic [csvrfp_pkg::ERR_W-1:0]  rsp_error_code,
   input logic                          rsp_last
);
   import csvrfp_pkg::*;

   logic stalled;
   logic content_beat;

   assign stalled      = rsp_valid && !rsp_ready;
   assign content_beat = rsp_valid && rsp_has_byte;

   // a stalled result beat holds
   `CSVRFP_ASSERT_NEXT(a_rsp_hold, stalled, rsp_valid && $stable(rsp_data_byte) && $stable(rsp_has_byte) && $stable(rsp_field_end) && $stable(rsp_record_end) && $stable(rsp_last), "result beat changed while stalled")

   // content beats carry no marks and no error
   `CSVRFP_ASSERT_NOW(a_content_clean, content_beat, !rsp_field_end && !rsp_record_end && (rsp_error_code == ERR_NONE), "content beat with marks")

   // an error beat is the sole, final result of its byte
   `CSVRFP_ASSERT_NOW(a_err_alone, rsp_valid && (rsp_error_code != ERR_NONE), rsp_last && !rsp_has_byte && !rsp_field_end && !rsp_record_end, "malformed error beat")

   // record end always closes the byte's results and carries no content
   `CSVRFP_ASSERT_NOW(a_rec_end_last, rsp_valid && rsp_record_end, rsp_last && !rsp_has_byte && (rsp_data_byte == CH_NUL), "record end not final")

endmodule

bind csv_record_field_parser csvrfp_checker u_checker (.*);

// ===== tb/sv/testbench.sv =====
// testbench for the csv record field parser: random csv text checked against a built-in parser
`timescale 1ns / 1ps

module testbench;
   import csvrfp_pkg::*;

   // the watchdog trips after this many cycles with no beat on either side;
   // a correct run never goes longer than a sender gap plus a receiver stall
   // plus the pipeline without a beat
   localparam int STALL_LIMIT = 2000;
   // items left in the stream when idling stops for the closing stretch
   localparam int CALM_TAIL   = 40;
   // cycles allowed after the last expected beat for anything stray to appear
   localparam int DRAIN_WAIT  = 40;
   // rough number of input beats in one run
   localparam int ITEM_TARGET = 160;

   typedef struct packed {
      logic [BYTE_W-1:0] data_byte;
      logic              has_byte;
      logic              field_end;
      logic              record_end;
      logic [FIDX_W-1:0] field_index;
      logic [ERR_W-1:0]  error_code;
      logic              last;
   } csv_beat_type;

   typedef struct {
      logic [BYTE_W-1:0] ch;
      logic              eoi;
      bit                pause_first;   // hold this byte back until all output has drained
   } text_item_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   logic [BYTE_W-1:0] req_byte_req = '0;
   logic              req_end_of_input = 1'b0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   logic [BYTE_W-1:0] rsp_data_byte;
   logic              rsp_has_byte;
   logic              rsp_field_end;
   logic              rsp_record_end;
   logic [FIDX_W-1:0] rsp_field_index;
   logic [ERR_W-1:0]  rsp_error_code;
   logic              rsp_last;

   csv_record_field_parser uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_byte_req     (req_byte_req),
      .req_end_of_input (req_end_of_input),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_data_byte    (rsp_data_byte),
      .rsp_has_byte     (rsp_has_byte),
      .rsp_field_end    (rsp_field_end),
      .rsp_record_end   (rsp_record_end),
      .rsp_field_index  (rsp_field_index),
      .rsp_error_code   (rsp_error_code),
      .rsp_last         (rsp_last)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   // ------------------------------------------------------------------
   // stream of csv text still to send, and the beats the parser owes us
   // ------------------------------------------------------------------
   text_item_type text_stream[$];
   csv_beat_type  beats_due[$];
   bit            hold_next = 1'b0;

   int fault_count = 0;
   int quiet_cycles = 0;
   logic byte_taken = 1'b0;

   // ------------------------------------------------------------------
   // parser shadow state
   // ------------------------------------------------------------------
   logic           q_parity;     // running quote parity of the record
   logic           lf_pending;   // a CR ended the last record, swallow one LF
   logic           rec_shown;    // record has seen a non-blank byte
   field_mode_type fmode;
   logic           after_sep;    // field was opened by a comma
   logic [6:0]     nfield;
   logic [5:0]     nheld;
   logic [63:0]    held_tabs;    // bit i set: held blank i is a tab

   function automatic void note_beat(input logic [BYTE_W-1:0] b, input logic hb,
                                     input logic fe, input logic re,
                                     input logic [6:0] idx, input logic [ERR_W-1:0] err);
      csv_beat_type t;
      t.data_byte   = b;
      t.has_byte    = hb;
      t.field_end   = fe;
      t.record_end  = re;
      t.field_index = idx[FIDX_W-1:0];
      t.error_code  = err;
      t.last        = 1'b0;
      beats_due.push_back(t);
   endfunction

   function automatic void wipe_record();
      q_parity  = 1'b0;
      rec_shown = 1'b0;
      fmode     = MODE_START;
      after_sep = 1'b0;
      nfield    = '0;
      nheld     = '0;
      held_tabs = '0;
   endfunction

   function automatic void close_record();
      if (rec_shown) begin
         // dropped records and a trailing comma past the field limit get a bare record end
         if (fmode == MODE_DROP ||
             (fmode == MODE_START && after_sep && nfield >= MAX_FIELDS))
            note_beat('0, 1'b0, 1'b0, 1'b1, '0, ERR_NONE);
         else
            note_beat('0, 1'b0, 1'b1, 1'b1, nfield, ERR_NONE);
      end
      wipe_record();
   endfunction

   function automatic void finish_field();
      note_beat('0, 1'b0, 1'b1, 1'b0, nfield, ERR_NONE);
      nfield    = nfield + 1'b1;
      after_sep = 1'b1;
      fmode     = MODE_START;
   endfunction

   function automatic void take_content(input logic [BYTE_W-1:0] c);
      case (fmode)
         MODE_START: begin
            if (nfield >= MAX_FIELDS) begin
               note_beat('0, 1'b0, 1'b0, 1'b0, '0, ERR_MANY_FIELD);
               fmode = MODE_DROP;
            end else if (c == CH_QUOTE) begin
               after_sep = 1'b0;
               fmode     = MODE_QUOTED;
            end else if (c == CH_COMMA) begin
               finish_field();
            end else begin
               after_sep = 1'b0;
               note_beat(c, 1'b1, 1'b0, 1'b0, nfield, ERR_NONE);
               fmode = MODE_PLAIN;
            end
         end
         MODE_PLAIN: begin
            if (c == CH_COMMA)
               finish_field();
            else
               note_beat(c, 1'b1, 1'b0, 1'b0, nfield, ERR_NONE);
         end
         MODE_QUOTED: begin
            if (c == CH_QUOTE)
               fmode = MODE_QCLOSE;
            else
               note_beat(c, 1'b1, 1'b0, 1'b0, nfield, ERR_NONE);
         end
         MODE_QCLOSE: begin
            if (c == CH_QUOTE) begin
               // doubled quote inside a quoted field
               note_beat(CH_QUOTE, 1'b1, 1'b0, 1'b0, nfield, ERR_NONE);
               fmode = MODE_QUOTED;
            end else if (c == CH_COMMA) begin
               finish_field();
            end else begin
               // junk after the closing quote ends the field, rest of record dropped
               note_beat('0, 1'b0, 1'b1, 1'b0, nfield, ERR_NONE);
               nfield = nfield + 1'b1;
               fmode  = MODE_DROP;
            end
         end
         default: fmode = MODE_DROP;
      endcase
   endfunction

   // one accepted byte (or end of input) -> expected beats appended to beats_due
   function automatic void parse_char(input logic [BYTE_W-1:0] c, input logic eoi);
      int           first;
      int           i;
      csv_beat_type t;
      first = beats_due.size();
      if (eoi) begin
         lf_pending = 1'b0;
         close_record();
      end else if (c != CH_NUL) begin
         if (lf_pending && c == CH_LF) begin
            lf_pending = 1'b0;
         end else begin
            lf_pending = 1'b0;
            if ((c == CH_CR || c == CH_LF) && !q_parity) begin
               lf_pending = (c == CH_CR);
               close_record();
            end else begin
               if (c == CH_QUOTE)
                  q_parity = ~q_parity;
               if (!rec_shown && (c == CH_SPACE || c == CH_TAB)) begin
                  if (nheld >= BLANK_LIMIT) begin
                     note_beat('0, 1'b0, 1'b0, 1'b0, '0, ERR_BLANK_OVF);
                     nheld     = '0;
                     held_tabs = '0;
                     rec_shown = 1'b1;
                     fmode     = MODE_DROP;
                  end else begin
                     held_tabs[nheld] = (c == CH_TAB);
                     nheld = nheld + 1'b1;
                  end
               end else begin
                  if (!rec_shown) begin
                     // record proved visible: replay held blanks into field 0
                     rec_shown = 1'b1;
                     for (i = 0; i < nheld; i++)
                        note_beat(held_tabs[i] ? CH_TAB : CH_SPACE, 1'b1, 1'b0, 1'b0,
                                  '0, ERR_NONE);
                     if (nheld > 0)
                        fmode = MODE_PLAIN;
                     nheld     = '0;
                     held_tabs = '0;
                  end
                  take_content(c);
               end
            end
         end
      end
      if (beats_due.size() > first) begin
         t = beats_due.pop_back();
         t.last = 1'b1;
         beats_due.push_back(t);
      end
   endfunction

   // ------------------------------------------------------------------
   // stimulus builders
   // ------------------------------------------------------------------
   task automatic add_byte(input logic [BYTE_W-1:0] c);
      text_item_type it;
      it.ch          = c;
      it.eoi         = 1'b0;
      it.pause_first = hold_next;
      hold_next      = 1'b0;
      text_stream.push_back(it);
   endtask

   task automatic add_eof();
      text_item_type it;
      it.ch          = BYTE_W'($urandom_range(0, 255));   // byte is ignored on end of input
      it.eoi         = 1'b1;
      it.pause_first = hold_next;
      hold_next      = 1'b0;
      text_stream.push_back(it);
   endtask

   task automatic add_text(input string s);
      int i;
      for (i = 0; i < s.len(); i++)
         add_byte(s[i]);
   endtask

   function automatic logic [BYTE_W-1:0] text_char();
      logic [BYTE_W-1:0] c;
      do
         c = BYTE_W'($urandom_range(1, 255));
      while (c == CH_QUOTE || c == CH_COMMA || c == CH_CR || c == CH_LF);
      return c;
   endfunction

   function automatic logic [BYTE_W-1:0] blank_char();
      return $urandom_range(0, 1) ? CH_TAB : CH_SPACE;
   endfunction

   task automatic add_terminator();
      case ($urandom_range(0, 3))
         0: add_byte(CH_CR);
         1: add_byte(CH_LF);
         2: begin
            add_byte(CH_CR);
            add_byte(CH_LF);
         end
         default: add_eof();
      endcase
   endtask

   // mostly well-formed record with random content, at times with junk after a closing quote
   task automatic add_record();
      int nb;
      int nf;
      int len;
      int i;
      int j;
      nb = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 4) : 0;
      for (i = 0; i < nb; i++)
         add_byte(blank_char());
      nf = $urandom_range(1, 4);
      for (i = 0; i < nf; i++) begin
         if (i > 0)
            add_byte(CH_COMMA);
         len = $urandom_range(0, 4);
         if ($urandom_range(0, 2) == 0) begin
            add_byte(CH_QUOTE);
            for (j = 0; j < len; j++) begin
               case ($urandom_range(0, 7))
                  0: begin
                     add_byte(CH_QUOTE);
                     add_byte(CH_QUOTE);
                  end
                  1: add_byte(CH_COMMA);
                  2: add_byte($urandom_range(0, 1) ? CH_CR : CH_LF);
                  default: add_byte(text_char());
               endcase
            end
            add_byte(CH_QUOTE);
            if ($urandom_range(0, 11) == 0)
               add_byte(text_char());
         end else begin
            for (j = 0; j < len; j++)
               add_byte(text_char());
         end
      end
      if ($urandom_range(0, 5) == 0)
         add_byte(CH_COMMA);
      add_terminator();
   endtask

   // raw bytes, biased toward the characters the parser cares about
   task automatic add_noise();
      int n;
      int i;
      n = $urandom_range(1, 8);
      for (i = 0; i < n; i++) begin
         if ($urandom_range(0, 3) == 0) begin
            case ($urandom_range(0, 5))
               0: add_byte(CH_QUOTE);
               1: add_byte(CH_COMMA);
               2: add_byte(CH_CR);
               3: add_byte(CH_LF);
               4: add_byte(CH_SPACE);
               default: add_byte(CH_TAB);
            endcase
         end else begin
            add_byte(BYTE_W'($urandom_range(1, 255)));
         end
      end
      if ($urandom_range(0, 3) == 0)
         add_eof();
   endtask

   task automatic add_blank_record();
      int n;
      int i;
      n = $urandom_range(0, 5);
      for (i = 0; i < n; i++)
         add_byte(blank_char());
      add_terminator();
   endtask

   // fills fields up to the limit; overflow adds content for one field too many,
   // otherwise the record closes on a trailing comma at the limit
   task automatic add_field_flood(input bit overflow);
      int i;
      for (i = 0; i < MAX_FIELDS - 1; i++)
         add_byte(CH_COMMA);
      add_byte(text_char());
      add_byte(CH_COMMA);
      if (overflow) begin
         add_byte(text_char());
         add_byte(CH_COMMA);
         add_byte(text_char());
      end
      add_byte(CH_LF);
   endtask

   // a full blank hold, or one that runs past the limit
   task automatic add_blank_pile(input bit overflow);
      int n;
      int i;
      n = overflow ? BLANK_LIMIT + $urandom_range(1, 3) : BLANK_LIMIT;
      for (i = 0; i < n; i++)
         add_byte(blank_char());
      add_byte(text_char());
      add_terminator();
   endtask

   function automatic int pick_pct();
      case ($urandom_range(0, 2))
         0:       return 0;
         1:       return 20;
         default: return 50;
      endcase
   endfunction

   // ------------------------------------------------------------------
   // driver: presents the next byte at the falling edge, random gaps
   // ------------------------------------------------------------------
   text_item_type next_item;
   int tx_gap = 0;
   int tx_sent = 0;
   int tx_pct = 20;

   always @(negedge clock) begin
      if (!reset && (!req_valid || byte_taken)) begin
         if (tx_gap > 0) begin
            tx_gap--;
            req_valid <= 1'b0;
         end else if (text_stream.size() == 0 ||
                      (text_stream[0].pause_first && beats_due.size() != 0)) begin
            // out of text, or holding off until the parser has emptied
            req_valid <= 1'b0;
         end else begin
            next_item = text_stream.pop_front();
            req_byte_req     <= next_item.ch;
            req_end_of_input <= next_item.eoi;
            req_valid        <= 1'b1;
            tx_sent++;
            if (tx_sent % 32 == 0)
               tx_pct = pick_pct();
            // gap starts once this beat is taken; none in the closing stretch
            if (text_stream.size() >= CALM_TAIL && $urandom_range(0, 99) < tx_pct)
               tx_gap = $urandom_range(1, 16);
         end
      end
   end

   // ------------------------------------------------------------------
   // receiver: backpressure in random bursts, off near the end
   // ------------------------------------------------------------------
   int rx_stall = 0;
   int rx_cycles = 0;
   int rx_pct = 20;

   always @(negedge clock) begin
      if (!reset) begin
         rx_cycles++;
         if (rx_cycles % 32 == 0)
            rx_pct = pick_pct();
         if (rx_stall > 0) begin
            rx_stall--;
            rsp_ready <= 1'b0;
         end else if (text_stream.size() >= CALM_TAIL && $urandom_range(0, 99) < rx_pct) begin
            rx_stall = $urandom_range(0, 15);
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // ------------------------------------------------------------------
   // monitor: predicts on every input beat, checks every output beat
   // ------------------------------------------------------------------
   function automatic void report_fault(input csv_beat_type want, input csv_beat_type got,
                                        input bit stray);
      fault_count++;
      if (fault_count <= 10) begin
         if (stray)
            $display("unexpected beat: byte=%02h hb=%0d fe=%0d re=%0d idx=%0d err=%0d last=%0d",
                     got.data_byte, got.has_byte, got.field_end, got.record_end,
                     got.field_index, got.error_code, got.last);
         else
            $display("mismatch: exp byte=%02h hb=%0d fe=%0d re=%0d idx=%0d err=%0d last=%0d",
                     want.data_byte, want.has_byte, want.field_end, want.record_end,
                     want.field_index, want.error_code, want.last);
         if (!stray)
            $display("          got byte=%02h hb=%0d fe=%0d re=%0d idx=%0d err=%0d last=%0d",
                     got.data_byte, got.has_byte, got.field_end, got.record_end,
                     got.field_index, got.error_code, got.last);
      end
   endfunction

   csv_beat_type got_beat;
   csv_beat_type want_beat;

   always @(posedge clock) begin
      if (reset) begin
         byte_taken <= 1'b0;
         lf_pending = 1'b0;
         wipe_record();
         beats_due.delete();
         quiet_cycles = 0;
      end else begin
         byte_taken <= req_valid && req_ready;
         if (req_valid && req_ready)
            parse_char(req_byte_req, req_end_of_input);
         if (rsp_valid && rsp_ready) begin
            got_beat = {rsp_data_byte, rsp_has_byte, rsp_field_end, rsp_record_end,
                        rsp_field_index, rsp_error_code, rsp_last};
            if (beats_due.size() == 0) begin
               report_fault(got_beat, got_beat, 1'b1);
            end else begin
               want_beat = beats_due.pop_front();
               if (got_beat !== want_beat)
                  report_fault(want_beat, got_beat, 1'b0);
            end
         end
         // watchdog: no beat on either side for too long means a hang
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("tb: failure");
            $finish;
         end
      end
   end

   // ------------------------------------------------------------------
   // stimulus and end of run
   // ------------------------------------------------------------------
   int rec_no;

   initial begin
      // directed: quoted field with a doubled quote, empty field, trailing comma, CR LF
      add_text("\"q\"\"\",,\r\n");
      // blank-only record is skipped entirely
      add_text(" \t\n");
      // held blanks replayed ahead of the byte extremes, closed by end of input
      add_byte(CH_TAB);
      add_byte(8'hFF);
      add_byte(8'h01);
      add_eof();
      // content after a closing quote, then a lone CR followed by a non-LF byte
      add_text("\"z\"w\r");
      // quote left open when end of input arrives
      add_text("\"ab");
      add_eof();
      // end of input with no record open
      add_eof();

      // random part: mostly well-formed records, some noise and blank records,
      // with the long limit cases dropped in early
      rec_no = 0;
      while (text_stream.size() < ITEM_TARGET || rec_no <= 8) begin
         case (rec_no)
            2: add_field_flood(1'b0);
            4: add_blank_pile(1'b1);
            6: add_field_flood(1'b1);
            8: add_blank_pile(1'b0);
            default: ;
         endcase
         if (rec_no == 5 || $urandom_range(0, 9) == 0)
            hold_next = 1'b1;
         case ($urandom_range(0, 19))
            0, 1: add_noise();
            2, 3: add_blank_record();
            default: add_record();
         endcase
         rec_no++;
      end

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // let all text go in, then wait for the parser to drain
      while (text_stream.size() != 0 || req_valid) begin
         @(posedge clock);
         #1;
      end
      while (beats_due.size() != 0) begin
         @(posedge clock);
         #1;
      end
      // catch any stray beat that shows up late
      repeat (DRAIN_WAIT) @(posedge clock);
      #1;
      if (fault_count == 0 && beats_due.size() == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule
